@@ hw/rtl/bilinear_splat_color_mixer_unit_defines.svh @@
// assertion macros for the bilinear splat color mixer
`ifndef BILINEAR_SPLAT_COLOR_MIXER_UNIT_DEFINES_SVH
`define BILINEAR_SPLAT_COLOR_MIXER_UNIT_DEFINES_SVH

// same-cycle implication
`define BSCM_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bscm assertion failed");

// next-cycle implication
`define BSCM_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bscm assertion failed");

`endif

@@ hw/rtl/bscm_pkg.sv @@
// shared types and constants of the bilinear splat color mixer
`default_nettype none

package bscm_pkg;

    localparam int MARGIN  = 4;
    localparam int CELL_W  = 11;
    localparam int WGT_W   = 17;
    localparam int Q_DEPTH = 2;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DROP  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic [2:0] REG_EXT_LEFT   = 3'd0;
    localparam logic [2:0] REG_EXT_BOTTOM = 3'd1;
    localparam logic [2:0] REG_INV_WIDTH  = 3'd2;
    localparam logic [2:0] REG_INV_HEIGHT = 3'd3;
    localparam logic [2:0] REG_COLOR0     = 3'd4;
    localparam logic [2:0] REG_COLOR1     = 3'd5;
    localparam logic [2:0] REG_COLOR2     = 3'd6;
    localparam logic [2:0] REG_COLOR3     = 3'd7;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [1:0]         group_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [5:0]         read_column;
        logic [5:0]         read_row;
    } cmd_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] status;
    } res_t;

    typedef enum logic [2:0] {
        K_ADD,
        K_READ,
        K_CLEAR,
        K_NOP,
        K_DROP,
        K_EMPTY
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [1:0]         group;
        logic [CELL_W-1:0]  cx;
        logic [CELL_W-1:0]  cy;
        logic [WGT_W-1:0]   w00;
        logic [WGT_W-1:0]   w10;
        logic [WGT_W-1:0]   w01;
        logic [WGT_W-1:0]   w11;
    } job_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SCALE,
        F_WEIGHT,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_ADDR,
        B_READ,
        B_MOD,
        B_MIX,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/bilinear_splat_color_mixer_unit.sv @@
// top level of the bilinear splat color mixer
`default_nettype none
`include "bilinear_splat_color_mixer_unit_defines.svh"

// Splats weighted points into a (GRID_W+4) x (GRID_H+4) x GROUPS density store
// and mixes group colors on a cell read. A word is taken when start is high and
// busy is low; every word gives one result, shown for one cycle with done high,
// and the receiver cannot stall it. The front end scales and clips the point and
// hands jobs to a two-entry queue, so it can take a new word while the back end
// works. The back end is bound by its density store of one read and one write
// port: an add is four read-modify-writes (address, read, modify), a read is a
// fetch, a mix over the GROUPS lanes and a divide for eight quotient bits, and
// dropped points and reads outside the grid go straight to the result. A clear,
// and the pass that runs after reset, write one store row per cycle over all
// (GRID_W+4)*(GRID_H+4) rows (4624 at 64x64) with busy held high.
module bilinear_splat_color_mixer_unit #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64,
    parameter int GROUPS = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire bscm_pkg::cmd_t  cmd,
    output logic                 done,
    output bscm_pkg::res_t       result,
    input  wire logic            cfg_we,
    input  wire logic [2:0]      cfg_index,
    input  wire logic [31:0]     cfg_data
);

    logic [31:0]      ext_left_reg, ext_bottom_reg, inv_w_reg, inv_h_reg;
    logic [3:0][23:0] color_reg;

    logic            accept, front_busy, clearing;
    logic            push, q_full, q_empty, pop;
    bscm_pkg::job_t  job, head;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ext_left_reg   <= '0;
            ext_bottom_reg <= '0;
            inv_w_reg      <= 32'h0001_0000;
            inv_h_reg      <= 32'h0001_0000;
            color_reg      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bscm_pkg::REG_EXT_LEFT:   ext_left_reg   <= cfg_data;
                bscm_pkg::REG_EXT_BOTTOM: ext_bottom_reg <= cfg_data;
                bscm_pkg::REG_INV_WIDTH:  inv_w_reg      <= cfg_data;
                bscm_pkg::REG_INV_HEIGHT: inv_h_reg      <= cfg_data;
                bscm_pkg::REG_COLOR0:     color_reg[0]   <= cfg_data[23:0];
                bscm_pkg::REG_COLOR1:     color_reg[1]   <= cfg_data[23:0];
                bscm_pkg::REG_COLOR2:     color_reg[2]   <= cfg_data[23:0];
                bscm_pkg::REG_COLOR3:     color_reg[3]   <= cfg_data[23:0];
                default:                  ;
            endcase
        end
    end

    assign busy   = front_busy || clearing;
    assign accept = start && !busy;

    bscm_front #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H),
        .GROUPS (GROUPS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd        (cmd),
        .ext_left   (ext_left_reg),
        .ext_bottom (ext_bottom_reg),
        .inv_w      (inv_w_reg),
        .inv_h      (inv_h_reg),
        .q_full     (q_full),
        .push       (push),
        .job        (job),
        .front_busy (front_busy)
    );

    bscm_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .job_in (job),
        .full   (q_full),
        .pop    (pop),
        .empty  (q_empty),
        .head   (head)
    );

    bscm_back #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H),
        .GROUPS (GROUPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .head     (head),
        .pop      (pop),
        .colors   (color_reg),
        .clearing (clearing),
        .done     (done),
        .result   (result)
    );

    `BSCM_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `BSCM_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
    `BSCM_ASSERT_IMPL(a_black_unless_ok, clk, rst_n, done && (result.status != bscm_pkg::ST_OK), (result.red == 8'd0) && (result.green == 8'd0) && (result.blue == 8'd0))

endmodule

`default_nettype wire

@@ hw/rtl/bscm_front.sv @@
// front end: accepts a word, scales and clips the point, builds a job
`default_nettype none

module bscm_front #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64,
    parameter int GROUPS = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire bscm_pkg::cmd_t  cmd,
    input  wire logic [31:0]     ext_left,
    input  wire logic [31:0]     ext_bottom,
    input  wire logic [31:0]     inv_w,
    input  wire logic [31:0]     inv_h,
    input  wire logic            q_full,
    output logic                 push,
    output bscm_pkg::job_t       job,
    output logic                 front_busy
);

    localparam logic [47:0] LIM_X = 48'(GRID_W + 2) << 16;
    localparam logic [47:0] LIM_Y = 48'(GRID_H + 2) << 16;

    bscm_pkg::front_state_t state_reg, state_next;

    bscm_pkg::cmd_t                  cmd_reg;
    logic                            negx_reg, negy_reg;
    logic [63:0]                     prodx_reg, prody_reg;
    bscm_pkg::kind_t                 kind_reg;
    logic [bscm_pkg::CELL_W-1:0]     cx_reg, cy_reg;
    logic [15:0]                     fx_reg, fy_reg, w11_reg;

    logic [32:0] dx, dy;
    logic [47:0] ux, uy;
    logic        outx, outy;
    logic [31:0] fxy;
    bscm_pkg::kind_t kind_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= bscm_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bscm_pkg::F_IDLE:
            begin
                if (accept) begin
                    state_next = bscm_pkg::F_SCALE;
                end
            end
            bscm_pkg::F_SCALE:  state_next = bscm_pkg::F_WEIGHT;
            bscm_pkg::F_WEIGHT: state_next = bscm_pkg::F_PUSH;
            bscm_pkg::F_PUSH:
            begin
                if (!q_full) begin
                    state_next = bscm_pkg::F_IDLE;
                end
            end
            default: state_next = bscm_pkg::F_IDLE;
        endcase
    end

    // differences are exact at 33 bits
    assign dx = {cmd_reg.point_x[31], cmd_reg.point_x} - {ext_left[31], ext_left};
    assign dy = {cmd_reg.point_y[31], cmd_reg.point_y} - {ext_bottom[31], ext_bottom};

    assign ux   = prodx_reg[63:16];
    assign uy   = prody_reg[63:16];
    assign outx = negx_reg || (ux > LIM_X);
    assign outy = negy_reg || (uy > LIM_Y);
    assign fxy  = ux[15:0] * uy[15:0];

    always_comb begin
        unique case (cmd_reg.opcode)
            bscm_pkg::OP_ADD:
            begin
                if (({1'b0, cmd_reg.group_index} >= 3'(GROUPS)) || outx || outy) begin
                    kind_next = bscm_pkg::K_DROP;
                end else begin
                    kind_next = bscm_pkg::K_ADD;
                end
            end
            bscm_pkg::OP_READ:
            begin
                if ((bscm_pkg::CELL_W'(cmd_reg.read_column) >= bscm_pkg::CELL_W'(GRID_W))
                    || (bscm_pkg::CELL_W'(cmd_reg.read_row) >= bscm_pkg::CELL_W'(GRID_H))) begin
                    kind_next = bscm_pkg::K_EMPTY;
                end else begin
                    kind_next = bscm_pkg::K_READ;
                end
            end
            bscm_pkg::OP_CLEAR: kind_next = bscm_pkg::K_CLEAR;
            default:            kind_next = bscm_pkg::K_NOP;
        endcase
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            cmd_reg <= cmd;
        end
        if (state_reg == bscm_pkg::F_SCALE) begin
            negx_reg  <= dx[32];
            negy_reg  <= dy[32];
            prodx_reg <= 64'(dx[31:0]) * 64'(inv_w);
            prody_reg <= 64'(dy[31:0]) * 64'(inv_h);
        end
        if (state_reg == bscm_pkg::F_WEIGHT) begin
            kind_reg <= kind_next;
            fx_reg   <= ux[15:0];
            fy_reg   <= uy[15:0];
            w11_reg  <= fxy[31:16];
            if (cmd_reg.opcode == bscm_pkg::OP_READ) begin
                // visible grid starts two cells into the store
                cx_reg <= bscm_pkg::CELL_W'(cmd_reg.read_column) + bscm_pkg::CELL_W'(2);
                cy_reg <= bscm_pkg::CELL_W'(cmd_reg.read_row) + bscm_pkg::CELL_W'(2);
            end else begin
                cx_reg <= ux[16 +: bscm_pkg::CELL_W];
                cy_reg <= uy[16 +: bscm_pkg::CELL_W];
            end
        end
    end

    always_comb begin
        job       = '0;
        job.kind  = kind_reg;
        job.group = cmd_reg.group_index;
        job.cx    = cx_reg;
        job.cy    = cy_reg;
        job.w11   = {1'b0, w11_reg};
        job.w10   = {1'b0, fx_reg} - {1'b0, w11_reg};
        job.w01   = {1'b0, fy_reg} - {1'b0, w11_reg};
        job.w00   = 17'h10000 - {1'b0, fx_reg} - {1'b0, fy_reg} + {1'b0, w11_reg};
    end

    assign push       = (state_reg == bscm_pkg::F_PUSH) && !q_full;
    assign front_busy = (state_reg != bscm_pkg::F_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/bscm_queue.sv @@
// short job queue between front and back end
`default_nettype none

module bscm_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire bscm_pkg::job_t  job_in,
    output logic                 full,
    input  wire logic            pop,
    output logic                 empty,
    output bscm_pkg::job_t       head
);

    localparam int PTR_W = $clog2(bscm_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(bscm_pkg::Q_DEPTH + 1);

    bscm_pkg::job_t   entries_reg [bscm_pkg::Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= job_in;
        end
    end

    assign full  = (count_reg == CNT_W'(bscm_pkg::Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

endmodule

`default_nettype wire

@@ hw/rtl/bscm_back.sv @@
// back end: density store, splat read-modify-writes, color mix and divide
`default_nettype none

module bscm_back #(
    parameter int GRID_W = 64,
    parameter int GRID_H = 64,
    parameter int GROUPS = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire bscm_pkg::job_t    head,
    output logic                   pop,
    input  wire logic [3:0][23:0]  colors,
    output logic                   clearing,
    output logic                   done,
    output bscm_pkg::res_t         result
);

    localparam int STORE_W = GRID_W + bscm_pkg::MARGIN;
    localparam int STORE_H = GRID_H + bscm_pkg::MARGIN;
    localparam int CELLS   = STORE_W * STORE_H;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int ROW_W   = GROUPS * 32;
    localparam int IDX_W   = 2 * bscm_pkg::CELL_W;

    bscm_pkg::back_state_t state_reg, state_next;

    logic [ROW_W-1:0] mem [CELLS];
    logic [ROW_W-1:0] rdata_reg;

    bscm_pkg::job_t      job_reg;
    logic [ADDR_W-1:0]   clr_addr_reg, addr_reg;
    logic                clr_emit_reg;
    logic [1:0]          corner_reg, grp_reg;
    logic [2:0]          bit_reg;
    logic                sat_reg;
    logic [33:0]         total_reg;
    logic [2:0][41:0]    acc_reg;
    logic [2:0][7:0]     quot_reg;
    logic [1:0]          status_reg;
    logic                done_reg;
    bscm_pkg::res_t      result_reg;

    logic [bscm_pkg::CELL_W-1:0] cell_x, cell_y;
    logic [IDX_W-1:0]            cell_idx;
    logic [bscm_pkg::WGT_W-1:0]  wgt;
    logic [31:0]                 old_lane, new_lane, mix_d;
    logic [32:0]                 sum33;
    logic                        sat_now;
    logic [ROW_W-1:0]            mod_row;
    logic [41:0]                 shifted;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [ROW_W-1:0]            mem_wdata;
    logic                        clr_last;

    assign clr_last = (clr_addr_reg == ADDR_W'(CELLS - 1));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= bscm_pkg::B_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        unique case (state_reg)
            bscm_pkg::B_CLEAR:
            begin
                if (clr_last) begin
                    state_next = clr_emit_reg ? bscm_pkg::B_DONE : bscm_pkg::B_IDLE;
                end
            end
            bscm_pkg::B_IDLE:
            begin
                if (!q_empty) begin
                    pop = 1'b1;
                    unique case (head.kind) inside
                        bscm_pkg::K_ADD,
                        bscm_pkg::K_READ:  state_next = bscm_pkg::B_ADDR;
                        bscm_pkg::K_CLEAR: state_next = bscm_pkg::B_CLEAR;
                        default:           state_next = bscm_pkg::B_DONE;
                    endcase
                end
            end
            bscm_pkg::B_ADDR: state_next = bscm_pkg::B_READ;
            bscm_pkg::B_READ:
            begin
                state_next = (job_reg.kind == bscm_pkg::K_ADD) ? bscm_pkg::B_MOD
                                                               : bscm_pkg::B_MIX;
            end
            bscm_pkg::B_MOD:
            begin
                state_next = (corner_reg == 2'd3) ? bscm_pkg::B_DONE : bscm_pkg::B_ADDR;
            end
            bscm_pkg::B_MIX:
            begin
                if (grp_reg == 2'(GROUPS - 1)) begin
                    state_next = bscm_pkg::B_DIV;
                end
            end
            bscm_pkg::B_DIV:
            begin
                if (bit_reg == 3'd0) begin
                    state_next = bscm_pkg::B_DONE;
                end
            end
            bscm_pkg::B_DONE: state_next = bscm_pkg::B_IDLE;
            default:          state_next = bscm_pkg::B_IDLE;
        endcase
    end

    // corner order: (0,0) (1,0) (0,1) (1,1)
    assign cell_x   = job_reg.cx + bscm_pkg::CELL_W'(corner_reg[0]);
    assign cell_y   = job_reg.cy + bscm_pkg::CELL_W'(corner_reg[1]);
    assign cell_idx = IDX_W'(cell_y) * IDX_W'(STORE_W) + IDX_W'(cell_x);

    always_comb begin
        case (corner_reg)
            2'd0:    wgt = job_reg.w00;
            2'd1:    wgt = job_reg.w10;
            2'd2:    wgt = job_reg.w01;
            default: wgt = job_reg.w11;
        endcase
    end

    always_comb begin
        old_lane = '0;
        mix_d    = '0;
        for (int g = 0; g < GROUPS; g++) begin
            if (2'(g) == job_reg.group) begin
                old_lane = rdata_reg[g*32 +: 32];
            end
            if (2'(g) == grp_reg) begin
                mix_d = rdata_reg[g*32 +: 32];
            end
        end
    end

    assign sum33    = {1'b0, old_lane} + 33'(wgt);
    assign sat_now  = sum33[32];
    assign new_lane = sat_now ? 32'hFFFF_FFFF : sum33[31:0];

    always_comb begin
        mod_row = rdata_reg;
        for (int g = 0; g < GROUPS; g++) begin
            if (2'(g) == job_reg.group) begin
                mod_row[g*32 +: 32] = new_lane;
            end
        end
    end

    assign shifted = {8'd0, total_reg} << bit_reg;

    assign mem_we    = (state_reg == bscm_pkg::B_CLEAR) || (state_reg == bscm_pkg::B_MOD);
    assign mem_waddr = (state_reg == bscm_pkg::B_CLEAR) ? clr_addr_reg : addr_reg;
    assign mem_wdata = (state_reg == bscm_pkg::B_CLEAR) ? '0 : mod_row;

    always_ff @(posedge clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clr_addr_reg <= '0;
            clr_emit_reg <= 1'b0;
            corner_reg   <= '0;
            grp_reg      <= '0;
            bit_reg      <= '0;
            done_reg     <= 1'b0;
        end else begin
            done_reg <= (state_reg == bscm_pkg::B_DONE);
            if (pop) begin
                clr_addr_reg <= '0;
                clr_emit_reg <= (head.kind == bscm_pkg::K_CLEAR);
                corner_reg   <= '0;
                grp_reg      <= '0;
                bit_reg      <= 3'd7;
            end
            if (state_reg == bscm_pkg::B_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            if (state_reg == bscm_pkg::B_MOD) begin
                corner_reg <= corner_reg + 2'd1;
            end
            if (state_reg == bscm_pkg::B_MIX) begin
                grp_reg <= grp_reg + 2'd1;
            end
            if (state_reg == bscm_pkg::B_DIV) begin
                bit_reg <= bit_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (pop) begin
            job_reg   <= head;
            sat_reg   <= 1'b0;
            total_reg <= '0;
            acc_reg   <= '0;
            quot_reg  <= '0;
            case (head.kind)
                bscm_pkg::K_DROP:  status_reg <= bscm_pkg::ST_DROP;
                bscm_pkg::K_EMPTY: status_reg <= bscm_pkg::ST_EMPTY;
                default:           status_reg <= bscm_pkg::ST_OK;
            endcase
        end
        if (state_reg == bscm_pkg::B_ADDR) begin
            addr_reg <= cell_idx[ADDR_W-1:0];
        end
        if (state_reg == bscm_pkg::B_MOD) begin
            sat_reg <= sat_reg | sat_now;
            if (corner_reg == 2'd3) begin
                status_reg <= (sat_reg || sat_now) ? bscm_pkg::ST_SAT : bscm_pkg::ST_OK;
            end
        end
        if (state_reg == bscm_pkg::B_MIX) begin
            total_reg <= total_reg + 34'(mix_d);
            for (int c = 0; c < 3; c++) begin
                acc_reg[c] <= acc_reg[c]
                              + (42'(mix_d) * 42'(colors[grp_reg][23-8*c -: 8]));
            end
        end
        if (state_reg == bscm_pkg::B_DIV) begin
            // restoring divide, one quotient bit per cycle for all three channels
            for (int c = 0; c < 3; c++) begin
                if (acc_reg[c] >= shifted) begin
                    acc_reg[c]           <= acc_reg[c] - shifted;
                    quot_reg[c][bit_reg] <= 1'b1;
                end
            end
            status_reg <= (total_reg == '0) ? bscm_pkg::ST_EMPTY : bscm_pkg::ST_OK;
        end
        if (state_reg == bscm_pkg::B_DONE) begin
            result_reg.status <= status_reg;
            if (status_reg == bscm_pkg::ST_OK) begin
                result_reg.red   <= quot_reg[0];
                result_reg.green <= quot_reg[1];
                result_reg.blue  <= quot_reg[2];
            end else begin
                result_reg.red   <= '0;
                result_reg.green <= '0;
                result_reg.blue  <= '0;
            end
        end
    end

    assign clearing = (state_reg == bscm_pkg::B_CLEAR);
    assign done     = done_reg;
    assign result   = result_reg;

endmodule

`default_nettype wire

@@ tb/tb_bilinear_splat_color_mixer_unit.sv @@
// self-checking testbench of the bilinear splat color mixer
`default_nettype none

module tb_bilinear_splat_color_mixer_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GW = 64;
    localparam int GH = 64;
    localparam int SW = GW + 4;
    localparam int SH = GH + 4;
    localparam int DEPTH = SW * SH * 4;
    localparam int IDLE_LIMIT = 20000;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    bscm_pkg::cmd_t cmd;
    logic           done;
    bscm_pkg::res_t result;
    logic           cfg_we;
    logic [2:0]     cfg_index;
    logic [31:0]    cfg_data;

    bilinear_splat_color_mixer_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow of the block's state
    logic [31:0] grid_density [DEPTH];
    logic [31:0] clip_left, clip_bottom, inv_w, inv_h;
    logic [23:0] group_rgb [4];

    bscm_pkg::cmd_t cmd_queue [$];
    bscm_pkg::res_t color_queue [$];
    int   errors = 0;
    int   idle_cycles = 0;
    int   burst_left = 0;
    int   gap_left = 0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task automatic queue_word(input bscm_pkg::cmd_t c);
        cmd_queue = {cmd_queue, c};
    endtask

    // scale one axis to cell units, 0 if clipped
    function automatic bit to_cell_units(input logic [31:0] p, input logic [31:0] e,
                                         input logic [31:0] inv, input int cells,
                                         output logic [63:0] u);
        logic signed [33:0] d;
        d = $signed({{2{p[31]}}, p}) - $signed({{2{e[31]}}, e});
        u = 64'd0;
        if (d < 0)
            return 1'b0;
        u = (64'(d[32:0]) * 64'(inv)) >> 16;
        return u <= (64'(cells + 2) << 16);
    endfunction

    function automatic bit splat_add(input int x, input int y, input int g,
                                     input logic [31:0] w);
        int i;
        i = (y * SW + x) * 4 + g;
        if (grid_density[i] > 32'hFFFF_FFFF - w) begin
            grid_density[i] = 32'hFFFF_FFFF;
            return 1'b1;
        end
        grid_density[i] = grid_density[i] + w;
        return 1'b0;
    endfunction

    function automatic bscm_pkg::res_t mix_cell_color(input bscm_pkg::cmd_t c);
        bscm_pkg::res_t r;
        logic [63:0] ux, uy, total, d;
        logic [63:0] acc [3];
        logic [31:0] fx, fy, w11;
        int cx, cy, base;
        bit sat;
        r = '0;
        r.status = bscm_pkg::ST_OK;
        case (c.opcode)
            bscm_pkg::OP_ADD: begin
                if (!to_cell_units(c.point_x, clip_left, inv_w, GW, ux) ||
                    !to_cell_units(c.point_y, clip_bottom, inv_h, GH, uy)) begin
                    r.status = bscm_pkg::ST_DROP;
                end else begin
                    cx = int'(ux >> 16);
                    cy = int'(uy >> 16);
                    fx = 32'(ux[15:0]);
                    fy = 32'(uy[15:0]);
                    w11 = (fx * fy) >> 16;
                    sat = splat_add(cx, cy, c.group_index, 32'd65536 - fx - fy + w11);
                    sat |= splat_add(cx + 1, cy, c.group_index, fx - w11);
                    sat |= splat_add(cx, cy + 1, c.group_index, fy - w11);
                    sat |= splat_add(cx + 1, cy + 1, c.group_index, w11);
                    if (sat)
                        r.status = bscm_pkg::ST_SAT;
                end
            end
            bscm_pkg::OP_READ: begin
                base = ((c.read_row + 2) * SW + (c.read_column + 2)) * 4;
                total = 0;
                acc[0] = 0;
                acc[1] = 0;
                acc[2] = 0;
                for (int g = 0; g < 4; g++) begin
                    d = 64'(grid_density[base + g]);
                    total += d;
                    acc[0] += d * group_rgb[g][23:16];
                    acc[1] += d * group_rgb[g][15:8];
                    acc[2] += d * group_rgb[g][7:0];
                end
                if (total == 0) begin
                    r.status = bscm_pkg::ST_EMPTY;
                end else begin
                    r.red   = 8'(acc[0] / total);
                    r.green = 8'(acc[1] / total);
                    r.blue  = 8'(acc[2] / total);
                end
            end
            bscm_pkg::OP_CLEAR: begin
                foreach (grid_density[i])
                    grid_density[i] = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    // driver: bursts of words with random gaps
    always @(posedge clk or negedge rst_n) begin
        bit go;
        bscm_pkg::res_t predicted;
        if (!rst_n) begin
            start <= 1'b0;
            cmd <= '0;
        end else begin
            if (start && !busy) begin
                predicted = mix_cell_color(cmd_queue.pop_front());
                color_queue = {color_queue, predicted};
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    burst_left = $urandom_range(1, 20);
                end
            end else if (gap_left > 0) begin
                gap_left--;
            end
            go = (cmd_queue.size() > 0) && (gap_left == 0);
            start <= go;
            if (go)
                cmd <= cmd_queue[0];
        end
    end

    // monitor and watchdog
    always @(posedge clk) begin
        bscm_pkg::res_t want;
        if (rst_n) begin
            if (done) begin
                if (color_queue.size() == 0) begin
                    report($sformatf("unexpected word %h", result));
                end else begin
                    want = color_queue.pop_front();
                    if (result.red !== want.red)
                        report($sformatf("red %h want %h", result.red, want.red));
                    if (result.green !== want.green)
                        report($sformatf("green %h want %h", result.green, want.green));
                    if (result.blue !== want.blue)
                        report($sformatf("blue %h want %h", result.blue, want.blue));
                    if (result.status !== want.status)
                        report($sformatf("status %0d want %0d", result.status, want.status));
                end
            end
            if (done || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            bscm_pkg::REG_EXT_LEFT:   clip_left = val;
            bscm_pkg::REG_EXT_BOTTOM: clip_bottom = val;
            bscm_pkg::REG_INV_WIDTH:  inv_w = val;
            bscm_pkg::REG_INV_HEIGHT: inv_h = val;
            default:                  group_rgb[2'(idx - bscm_pkg::REG_COLOR0)] = val[23:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(input logic [31:0] l, input logic [31:0] b, input logic [31:0] iw,
                         input logic [31:0] ih, input logic [23:0] c0, input logic [23:0] c1,
                         input logic [23:0] c2, input logic [23:0] c3);
        write_reg(bscm_pkg::REG_EXT_LEFT, l);
        write_reg(bscm_pkg::REG_EXT_BOTTOM, b);
        write_reg(bscm_pkg::REG_INV_WIDTH, iw);
        write_reg(bscm_pkg::REG_INV_HEIGHT, ih);
        write_reg(bscm_pkg::REG_COLOR0, 32'(c0));
        write_reg(bscm_pkg::REG_COLOR1, 32'(c1));
        write_reg(bscm_pkg::REG_COLOR2, 32'(c2));
        write_reg(bscm_pkg::REG_COLOR3, 32'(c3));
    endtask

    function automatic bscm_pkg::cmd_t make_word(input logic [1:0] op, input logic [1:0] g,
                                                 input logic [31:0] x, input logic [31:0] y,
                                                 input logic [5:0] col, input logic [5:0] row);
        bscm_pkg::cmd_t c;
        c.opcode = op;
        c.group_index = g;
        c.point_x = x;
        c.point_y = y;
        c.read_column = col;
        c.read_row = row;
        return c;
    endfunction

    // every field random except the opcode
    function automatic bscm_pkg::cmd_t rand_word(input logic [1:0] op);
        return make_word(op, 2'($urandom), $urandom, $urandom, 6'($urandom), 6'($urandom));
    endfunction

    // coordinate landing at a chosen cell position, mostly near the low corner
    function automatic logic [31:0] aim_coord(input logic [31:0] e, input logic [31:0] inv);
        longint u, p;
        if ($urandom_range(0, 9) == 0)
            u = $urandom_range(0, 70 << 16);
        else
            u = $urandom_range(2 << 16, 10 << 16);
        if (inv == 0)
            return e + $urandom_range(0, 1000);
        p = longint'($signed(e)) + (u << 16) / longint'(inv);
        if (p > 64'sd2147483647 || p < -64'sd2147483648)
            return $urandom;
        return 32'(p);
    endfunction

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || color_queue.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic run_random(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 1)
                queue_word(rand_word(bscm_pkg::OP_CLEAR));
            else if (k < 10)
                queue_word(rand_word($urandom_range(0, 1) ? bscm_pkg::OP_ADD
                                                          : bscm_pkg::OP_READ));
            else if (k < 60)
                queue_word(make_word(bscm_pkg::OP_ADD, 2'($urandom),
                                     aim_coord(clip_left, inv_w),
                                     aim_coord(clip_bottom, inv_h),
                                     6'($urandom), 6'($urandom)));
            else
                queue_word(make_word(bscm_pkg::OP_READ, 2'($urandom), $urandom, $urandom,
                                     6'($urandom_range(0, 9)), 6'($urandom_range(0, 9))));
        end
        wait_drained();
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        foreach (grid_density[i])
            grid_density[i] = '0;
        clip_left = 0;
        clip_bottom = 0;
        inv_w = 32'h0001_0000;
        inv_h = 32'h0001_0000;
        foreach (group_rgb[i])
            group_rgb[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: unit cells, corners, clip edges, every group and op
        setup(0, 0, 32'h0001_0000, 32'h0001_0000, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF);
        queue_word(make_word(bscm_pkg::OP_READ, 0, 0, 0, 0, 0));
        queue_word(make_word(bscm_pkg::OP_ADD, 0, 32'h0002_0000, 32'h0002_0000, 0, 0));
        queue_word(make_word(bscm_pkg::OP_ADD, 1, 32'h0002_8000, 32'h0002_4000, 0, 0));
        queue_word(make_word(bscm_pkg::OP_ADD, 2, 32'h0002_FFFF, 32'h0002_FFFF, 0, 0));
        queue_word(make_word(bscm_pkg::OP_ADD, 3, 32'h0003_0000, 32'h0002_0000, 0, 0));
        queue_word(make_word(bscm_pkg::OP_READ, 0, 0, 0, 0, 0));
        queue_word(make_word(bscm_pkg::OP_READ, 0, 0, 0, 1, 0));
        queue_word(make_word(bscm_pkg::OP_READ, 0, 0, 0, 0, 1));
        queue_word(make_word(bscm_pkg::OP_ADD, 0, 32'h0000_0000, 32'h0000_0000, 0, 0));
        queue_word(make_word(bscm_pkg::OP_ADD, 1, 32'h0042_0000, 32'h0042_0000, 0, 0));
        queue_word(make_word(bscm_pkg::OP_ADD, 2, 32'h0041_8000, 32'h0041_8000, 0, 0));
        queue_word(make_word(bscm_pkg::OP_READ, 0, 0, 0, 63, 63));
        queue_word(make_word(bscm_pkg::OP_ADD, 0, 32'h0042_0001, 32'h0002_0000, 0, 0));
        queue_word(make_word(bscm_pkg::OP_ADD, 0, 32'h0002_0000, 32'h0042_0001, 0, 0));
        queue_word(make_word(bscm_pkg::OP_ADD, 0, 32'hFFFF_FFFF, 32'h0002_0000, 0, 0));
        queue_word(make_word(bscm_pkg::OP_ADD, 3, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
        queue_word(make_word(bscm_pkg::OP_CLEAR, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 63, 63));
        queue_word(make_word(bscm_pkg::OP_READ, 0, 0, 0, 0, 0));
        queue_word(make_word(bscm_pkg::OP_ADD, 1, 32'h0005_1234, 32'h0006_ABCD, 0, 0));
        queue_word(make_word(bscm_pkg::OP_READ, 0, 0, 0, 3, 4));
        wait_drained();

        run_random(150);
        setup(32'h8000_0000, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001,
              24'h000000, 24'hFFFFFF, 24'h123456, 24'hABCDEF);
        run_random(100);
        setup(32'hFFF0_0000, 32'h0010_0000, 32'h0002_0000, 32'h0000_8000,
              24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h00FFFF);
        run_random(150);
        setup(32'h7FFF_FFFF, 32'h7FFF_0000, 32'hFFFF_FFFF, 32'h0000_0000,
              24'h808080, 24'h7F7F7F, 24'h010203, 24'hFEFDFC);
        run_random(100);
        setup(32'h0000_0000, 32'hFFFF_8000, 32'h0000_0000, 32'hFFFF_FFFF,
              24'h55AA55, 24'hAA55AA, 24'h000000, 24'hFFFFFF);
        run_random(100);
        setup(32'h1234_5678, 32'hEDCB_A988, 32'h0003_0000, 32'h0001_8000,
              24'hC0FFEE, 24'h0BADF0, 24'hDEAD00, 24'h00BEEF);
        run_random(230);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

@@ bilinear_splat_color_mixer_unit.f @@
+incdir+hw/rtl
hw/rtl/bscm_pkg.sv
hw/rtl/bscm_front.sv
hw/rtl/bscm_queue.sv
hw/rtl/bscm_back.sv
hw/rtl/bilinear_splat_color_mixer_unit.sv
tb/tb_bilinear_splat_color_mixer_unit.sv
